FILE: hw/rtl/su8d_pkg.sv
// Shared types and constants for the strict UTF-8 stream decoder.
// Used by the front, the queue, the back and the decoder core.
package su8d_pkg;

    localparam int SU8D_QUEUE_DEPTH = 4;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] CONT_MIN   = 8'h80;
    localparam logic [7:0] CONT_MAX   = 8'hBF;
    localparam logic [7:0] LEAD2_MIN  = 8'hC2;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MIN  = 8'hE0;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] LEAD3_SURR = 8'hED;
    localparam logic [7:0] LEAD4_MIN  = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] E0_LOW     = 8'hA0;
    localparam logic [7:0] ED_HIGH    = 8'h9F;
    localparam logic [7:0] F0_LOW     = 8'h90;
    localparam logic [7:0] F4_HIGH    = 8'h8F;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_INVALID
    } su8d_class_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        end_of_buffer;
        su8d_class_t byte_class;
        logic [7:0]  low_bound;
        logic [7:0]  high_bound;
    } su8d_item_t;

    typedef struct packed {
        logic        valid;
        logic        full;
    } su8d_queue_status_t;

endpackage

FILE: hw/rtl/su8d_if.sv
// Channel interfaces of the decoder: byte requests in, result requests out.
// Valid/ready handshake; no dependencies.
interface su8d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input has_byte,
                    input end_of_buffer, output ready);
endinterface

interface su8d_result_if;
    logic        valid;
    logic        ready;
    logic        has_code_point;
    logic [20:0] code_point;
    logic [2:0]  sequence_length;
    logic        malformed;
    logic        buffer_end;
    logic        buffer_valid;

    modport source (output valid, output has_code_point, output code_point,
                    output sequence_length, output malformed, output buffer_end,
                    output buffer_valid, input ready);
    modport sink   (input valid, input has_code_point, input code_point,
                    input sequence_length, input malformed, input buffer_end,
                    input buffer_valid, output ready);
endinterface

FILE: hw/rtl/su8d_front.sv
// Front of the decoder: accepts byte requests and classifies each byte.
// Depends on su8d_pkg and su8d_byte_if.
module su8d_front
    import su8d_pkg::*;
(
    su8d_byte_if.sink          bytes,
    input  su8d_queue_status_t queue_status,
    output logic               push,
    output su8d_item_t         item
);

    logic [7:0] b;

    assign b           = bytes.data_byte;
    assign bytes.ready = !queue_status.full;
    assign push        = bytes.valid && !queue_status.full;

    always_comb
    begin
        item.data_byte     = b;
        item.has_byte      = bytes.has_byte;
        item.end_of_buffer = bytes.end_of_buffer;
        item.low_bound     = CONT_MIN;
        item.high_bound    = CONT_MAX;
        if (b <= ASCII_MAX)
        begin
            item.byte_class = CLS_ASCII;
        end
        else if (b <= CONT_MAX)
        begin
            item.byte_class = CLS_CONT;
        end
        else if (b >= LEAD2_MIN && b <= LEAD2_MAX)
        begin
            item.byte_class = CLS_LEAD2;
        end
        else if (b >= LEAD3_MIN && b <= LEAD3_MAX)
        begin
            item.byte_class = CLS_LEAD3;
            if (b == LEAD3_MIN)
            begin
                item.low_bound = E0_LOW;
            end
            if (b == LEAD3_SURR)
            begin
                item.high_bound = ED_HIGH;
            end
        end
        else if (b >= LEAD4_MIN && b <= LEAD4_MAX)
        begin
            item.byte_class = CLS_LEAD4;
            if (b == LEAD4_MIN)
            begin
                item.low_bound = F0_LOW;
            end
            if (b == LEAD4_MAX)
            begin
                item.high_bound = F4_HIGH;
            end
        end
        else
        begin
            item.byte_class = CLS_INVALID;
        end
    end

endmodule

FILE: hw/rtl/su8d_queue.sv
// Short queue of classified bytes between the front and the back.
// Depends on su8d_pkg.
module su8d_queue
    import su8d_pkg::*;
#(
    parameter int DEPTH = SU8D_QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  su8d_item_t         push_item,
    input  logic               pop,
    output su8d_queue_status_t status,
    output su8d_item_t         head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    su8d_item_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign head         = entry_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && status.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/su8d_back.sv
// Back of the decoder: sequence state, range checks, code point assembly and
// the registered result request. Depends on su8d_pkg and su8d_result_if.
module su8d_back
    import su8d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  su8d_queue_status_t queue_status,
    input  su8d_item_t         item,
    output logic               pop,
    su8d_result_if.source      results
);

    logic [1:0]  rem_reg;
    logic [1:0]  rem_next;
    logic [20:0] pv_reg;
    logic [20:0] pv_next;
    logic [2:0]  size_reg;
    logic [2:0]  size_next;
    logic [7:0]  lo_reg;
    logic [7:0]  lo_next;
    logic [7:0]  hi_reg;
    logic [7:0]  hi_next;
    logic        err_reg;
    logic        err_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_cp_flag_reg;
    logic [20:0] out_cp_reg;
    logic [2:0]  out_len_reg;
    logic        out_bad_reg;
    logic        out_end_reg;
    logic        out_ok_reg;

    logic        got;
    logic        bad;
    logic        trunc;
    logic        ok;
    logic        emit;
    logic [20:0] cp;
    logic [2:0]  len;
    logic [20:0] shifted;
    logic [1:0]  rem_dec;
    logic [7:0]  b;

    assign b       = item.data_byte;
    assign shifted = {pv_reg[14:0], b[5:0]};
    assign rem_dec = rem_reg - 2'd1;
    assign pop     = queue_status.valid && (!out_valid_reg || results.ready);

    always_comb
    begin
        rem_next  = rem_reg;
        pv_next   = pv_reg;
        size_next = size_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        err_next  = err_reg;
        got       = 1'b0;
        bad       = 1'b0;
        trunc     = 1'b0;
        ok        = 1'b0;
        cp        = '0;
        len       = '0;
        if (item.has_byte && !err_reg)
        begin
            if (rem_reg == 2'd0)
            begin
                case (item.byte_class)
                    CLS_ASCII:
                    begin
                        got = 1'b1;
                        cp  = {13'd0, b};
                        len = 3'd1;
                    end
                    CLS_LEAD2:
                    begin
                        pv_next   = {16'd0, b[4:0]};
                        size_next = 3'd2;
                        rem_next  = 2'd1;
                        lo_next   = item.low_bound;
                        hi_next   = item.high_bound;
                    end
                    CLS_LEAD3:
                    begin
                        pv_next   = {17'd0, b[3:0]};
                        size_next = 3'd3;
                        rem_next  = 2'd2;
                        lo_next   = item.low_bound;
                        hi_next   = item.high_bound;
                    end
                    CLS_LEAD4:
                    begin
                        pv_next   = {18'd0, b[2:0]};
                        size_next = 3'd4;
                        rem_next  = 2'd3;
                        lo_next   = item.low_bound;
                        hi_next   = item.high_bound;
                    end
                    default:
                    begin
                        bad = 1'b1;
                    end
                endcase
            end
            else if (b < lo_reg || b > hi_reg)
            begin
                bad = 1'b1;
            end
            else
            begin
                lo_next = CONT_MIN;
                hi_next = CONT_MAX;
                if (rem_dec == 2'd0)
                begin
                    got       = 1'b1;
                    cp        = shifted;
                    len       = size_reg;
                    rem_next  = 2'd0;
                    pv_next   = '0;
                    size_next = '0;
                end
                else
                begin
                    pv_next  = shifted;
                    rem_next = rem_dec;
                end
            end
            if (bad)
            begin
                err_next  = 1'b1;
                rem_next  = 2'd0;
                pv_next   = '0;
                size_next = '0;
                lo_next   = CONT_MIN;
                hi_next   = CONT_MAX;
            end
        end
        if (item.end_of_buffer)
        begin
            trunc     = !err_next && (rem_next != 2'd0);
            ok        = !(err_next || trunc);
            bad       = bad || trunc;
            rem_next  = 2'd0;
            pv_next   = '0;
            size_next = '0;
            lo_next   = CONT_MIN;
            hi_next   = CONT_MAX;
            err_next  = 1'b0;
        end
        emit = got || bad || item.end_of_buffer;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= 2'd0;
            pv_reg        <= '0;
            size_reg      <= '0;
            lo_reg        <= CONT_MIN;
            hi_reg        <= CONT_MAX;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                rem_reg  <= rem_next;
                pv_reg   <= pv_next;
                size_reg <= size_next;
                lo_reg   <= lo_next;
                hi_reg   <= hi_next;
                err_reg  <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_cp_flag_reg <= got;
            out_cp_reg      <= cp;
            out_len_reg     <= len;
            out_bad_reg     <= bad;
            out_end_reg     <= item.end_of_buffer;
            out_ok_reg      <= ok;
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.has_code_point  = out_cp_flag_reg;
    assign results.code_point      = out_cp_reg;
    assign results.sequence_length = out_len_reg;
    assign results.malformed       = out_bad_reg;
    assign results.buffer_end      = out_end_reg;
    assign results.buffer_valid    = out_ok_reg;

endmodule

FILE: hw/rtl/strict_utf8_stream_decoder_core.sv
// Strict UTF-8 stream decoder: one byte request in per cycle while the queue is
// not full, and at most one result request out per byte. Each byte waits in the
// byte queue (QUEUE_DEPTH entries), and its result, if any, in the single result
// register set; the two absorb stalls on either side. Malformed input is
// flagged once per buffer; the rest of that buffer is dropped until its end
// item, which always yields a result with the buffer verdict.
module strict_utf8_stream_decoder_core
    import su8d_pkg::*;
#(
    parameter int QUEUE_DEPTH = SU8D_QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    su8d_byte_if.sink     bytes,
    su8d_result_if.source results
);

    su8d_queue_status_t queue_status;
    su8d_item_t         push_item;
    su8d_item_t         head_item;
    logic               push;
    logic               pop;

    su8d_front u_front (
        .bytes        (bytes),
        .queue_status (queue_status),
        .push         (push),
        .item         (push_item)
    );

    su8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .status    (queue_status),
        .head      (head_item)
    );

    su8d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .queue_status (queue_status),
        .item         (head_item),
        .pop          (pop),
        .results      (results)
    );

endmodule

FILE: hw/rtl/su8d_checker.sv
// Port-level checks of the strict UTF-8 stream decoder, bound to the top level.
// Depends on strict_utf8_stream_decoder_core and its channel interfaces.
module su8d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        has_code_point,
    input logic [20:0] code_point,
    input logic [2:0]  sequence_length,
    input logic        malformed,
    input logic        buffer_end,
    input logic        buffer_valid
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_point)
            && $stable(has_code_point) && $stable(buffer_end))
    else $error("result request changed while stalled");

    a_cp_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_code_point |-> !malformed && code_point <= 21'h10FFFF
            && sequence_length != 3'd0 && sequence_length <= 3'd4)
    else $error("bad code point result");

    a_no_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_code_point |-> code_point == 21'd0
            && sequence_length == 3'd0)
    else $error("stray code point bits");

    a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && buffer_valid |-> buffer_end && !malformed)
    else $error("buffer verdict inconsistent");

    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_code_point && sequence_length == 3'd1
            |-> code_point <= 21'h7F)
    else $error("one-byte code point out of range");

endmodule

bind strict_utf8_stream_decoder_core su8d_checker u_su8d_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (results.valid),
    .out_ready       (results.ready),
    .has_code_point  (results.has_code_point),
    .code_point      (results.code_point),
    .sequence_length (results.sequence_length),
    .malformed       (results.malformed),
    .buffer_end      (results.buffer_end),
    .buffer_valid    (results.buffer_valid)
);
